### sv/wft_pkg.sv
// Shared types and constants of the Wiegand frame transmitter.
package wft_pkg;

    localparam int PAYLOAD_W = 32;
    localparam int POS_W     = 6;
    localparam int PHASE_W   = 8;
    localparam int PULSE_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    // Item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEND = 1'b1;

    // Frame formats
    localparam logic [1:0] FMT_26 = 2'd0;
    localparam logic [1:0] FMT_34 = 2'd1;
    localparam logic [1:0] FMT_4  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS   = 1'd1;

    localparam logic [PULSE_W-1:0] PULSE_TICKS_RST = 4'd1;
    localparam logic [PHASE_W-1:0] BIT_TICKS_RST   = 8'd5;
    localparam logic [PHASE_W-1:0] BIT_TICKS_MIN   = 8'd2;

    localparam logic [POS_W-1:0] LAST_POS_26 = 6'd25;
    localparam logic [POS_W-1:0] LAST_POS_34 = 6'd33;
    localparam logic [POS_W-1:0] LAST_POS_4  = 6'd4;

    // Frame image built from one send item
    typedef struct packed {
        logic                 valid;
        logic [PAYLOAD_W-1:0] payload;
        logic                 even_par;
        logic                 odd_par;
        logic [POS_W-1:0]     last_pos;
        logic [POS_W-1:0]     first_pos;
        logic                 no_parity;
    } frame_load_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_ticks;
        logic [PHASE_W-1:0] bit_ticks;
    } timing_cfg_t;

    typedef struct packed {
        logic zero_pulse;
        logic one_pulse;
        logic busy_res;
        logic frame_done;
    } line_result_t;

endpackage

### sv/wft_loader.sv
// Packs the identifier bytes into a frame image and works out its parity bits.
module wft_loader (
    input  logic [1:0]           frame_format,
    input  logic                 byte_order,
    input  logic [7:0]           id_byte0,
    input  logic [7:0]           id_byte1,
    input  logic [7:0]           id_byte2,
    input  logic [7:0]           id_byte3,
    output wft_pkg::frame_load_t load
);
    import wft_pkg::*;

    always_comb begin
        load = '0;
        case (frame_format)
            FMT_26: begin
                load.valid    = 1'b1;
                load.payload  = byte_order ? {8'h00, id_byte2, id_byte1, id_byte0}
                                           : {8'h00, id_byte1, id_byte2, id_byte3};
                load.even_par = ^load.payload[23:12];
                load.odd_par  = ~(^load.payload[11:0]);
                load.last_pos = LAST_POS_26;
            end
            FMT_34: begin
                load.valid    = 1'b1;
                load.payload  = byte_order ? {id_byte0, id_byte1, id_byte2, id_byte3}
                                           : {id_byte3, id_byte2, id_byte1, id_byte0};
                load.even_par = ^load.payload[31:16];
                load.odd_par  = ~(^load.payload[15:0]);
                load.last_pos = LAST_POS_34;
            end
            FMT_4: begin
                load.valid     = 1'b1;
                load.payload   = {24'h000000, id_byte0};
                load.last_pos  = LAST_POS_4;
                load.first_pos = 6'd1;
                load.no_parity = 1'b1;
            end
            default: begin
                load.valid = 1'b0;
            end
        endcase
    end

endmodule

### sv/wft_sequencer.sv
// Frame state registers and the per-tick bit timer and line drive logic.
module wft_sequencer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  op,
    input  wft_pkg::frame_load_t  load,
    input  wft_pkg::timing_cfg_t  cfg,
    output wft_pkg::line_result_t result
);
    import wft_pkg::*;

    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic                 even_reg, even_next;
    logic                 odd_reg, odd_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS_W-1:0]     last_reg, last_next;
    logic                 no_par_reg, no_par_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic                 active_reg, active_next;
    logic [1:0]           lines_reg, lines_next;
    logic                 done;

    logic [PHASE_W-1:0]   bt;
    logic [PHASE_W-1:0]   bt_last;
    logic [PHASE_W-1:0]   pt;
    logic [POS_W-1:0]     idx;
    logic                 cur_bit;

    // Effective timing: bit at least two ticks, pulse in 1 .. bit-1
    always_comb begin
        bt      = (cfg.bit_ticks < BIT_TICKS_MIN) ? BIT_TICKS_MIN : cfg.bit_ticks;
        bt_last = bt - 8'd1;
        pt      = {4'h0, cfg.pulse_ticks};
        if (pt == 8'd0) begin
            pt = 8'd1;
        end
        if (pt > bt_last) begin
            pt = bt_last;
        end
    end

    // Bit under transmission
    always_comb begin
        idx     = '0;
        cur_bit = 1'b0;
        if (!no_par_reg) begin
            idx = last_reg - 6'd1 - pos_reg;
            if (pos_reg == '0) begin
                cur_bit = even_reg;
            end else if (pos_reg >= last_reg) begin
                cur_bit = odd_reg;
            end else begin
                cur_bit = payload_reg[idx[4:0]];
            end
        end else begin
            idx     = (last_reg >= pos_reg) ? (last_reg - pos_reg) : '0;
            cur_bit = payload_reg[idx[4:0]];
        end
    end

    always_comb begin
        payload_next = payload_reg;
        even_next    = even_reg;
        odd_next     = odd_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        no_par_next  = no_par_reg;
        phase_next   = phase_reg;
        active_next  = active_reg;
        lines_next   = lines_reg;
        done         = 1'b0;
        if (op == OP_SEND) begin
            if (load.valid) begin
                payload_next = load.payload;
                even_next    = load.even_par;
                odd_next     = load.odd_par;
                pos_next     = load.first_pos;
                last_next    = load.last_pos;
                no_par_next  = load.no_parity;
                phase_next   = '0;
                active_next  = 1'b1;
                lines_next   = 2'b00;
            end
        end else if (active_reg) begin
            if (phase_reg < pt) begin
                lines_next = cur_bit ? 2'b10 : 2'b01;
            end else begin
                lines_next = 2'b00;
            end
            if (phase_reg >= bt_last) begin
                phase_next = '0;
                if (pos_reg >= last_reg) begin
                    active_next = 1'b0;
                    lines_next  = 2'b00;
                    done        = 1'b1;
                end else begin
                    pos_next = pos_reg + 6'd1;
                end
            end else begin
                phase_next = phase_reg + 8'd1;
            end
        end else begin
            lines_next = 2'b00;
        end
        result.zero_pulse = lines_next[0];
        result.one_pulse  = lines_next[1];
        result.busy_res   = active_next;
        result.frame_done = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_reg <= '0;
            even_reg    <= 1'b0;
            odd_reg     <= 1'b0;
            pos_reg     <= '0;
            last_reg    <= '0;
            no_par_reg  <= 1'b0;
            phase_reg   <= '0;
            active_reg  <= 1'b0;
            lines_reg   <= 2'b00;
        end else if (accept) begin
            payload_reg <= payload_next;
            even_reg    <= even_next;
            odd_reg     <= odd_next;
            pos_reg     <= pos_next;
            last_reg    <= last_next;
            no_par_reg  <= no_par_next;
            phase_reg   <= phase_next;
            active_reg  <= active_next;
            lines_reg   <= lines_next;
        end
    end

endmodule

### sv/wiegand_frame_transmitter.sv
// Wiegand 26/34/4-bit frame transmitter: top level with config and result registers.
// A transfer's result is registered and valid at the output in the next cycle.
// Throughput: one item per cycle; a new item is taken whenever the result register
// is empty or its result is transferred in the same cycle.
// Reset (synchronous, active low): idle, lines released, pulse_ticks 1, bit_ticks 5.
module wiegand_frame_transmitter (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [wft_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wft_pkg::CFG_W-1:0]       cfg_wdata,
    // input items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_op,
    input  logic [1:0]                      s_frame_format,
    input  logic                            s_byte_order,
    input  logic [7:0]                      s_id_byte0,
    input  logic [7:0]                      s_id_byte1,
    input  logic [7:0]                      s_id_byte2,
    input  logic [7:0]                      s_id_byte3,
    // result items
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_zero_pulse,
    output logic                            m_one_pulse,
    output logic                            m_busy_res,
    output logic                            m_frame_done
);
    import wft_pkg::*;

    timing_cfg_t  cfg_reg;
    frame_load_t  load;
    line_result_t result;
    line_result_t res_reg;
    logic         m_valid_reg;
    logic         accept;

    // Take a new item when the result slot is free or draining this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Configuration registers; a write lands at the edge where the enable is high
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_ticks <= PULSE_TICKS_RST;
            cfg_reg.bit_ticks   <= BIT_TICKS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PULSE_TICKS: cfg_reg.pulse_ticks <= cfg_wdata[PULSE_W-1:0];
                CFG_BIT_TICKS:   cfg_reg.bit_ticks   <= cfg_wdata[PHASE_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Build the frame image from the send fields
    wft_loader u_loader (
        .frame_format (s_frame_format),
        .byte_order   (s_byte_order),
        .id_byte0     (s_id_byte0),
        .id_byte1     (s_id_byte1),
        .id_byte2     (s_id_byte2),
        .id_byte3     (s_id_byte3),
        .load         (load)
    );

    // Advance the bit timer and frame state on every transfer
    wft_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .op      (s_op),
        .load    (load),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Result register: hold until the downstream transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= result;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_zero_pulse = res_reg.zero_pulse;
    assign m_one_pulse  = res_reg.one_pulse;
    assign m_busy_res   = res_reg.busy_res;
    assign m_frame_done = res_reg.frame_done;

endmodule
